// ===== rtl/cipu_pkg.sv =====
package cipu_pkg;

	localparam int CW = 32;
	localparam int FB = 16;
	localparam int DW = CW - 1;
	localparam int AW = CW - 2;
	localparam int QW = AW;
	localparam int NW = AW + DW;
	localparam int NCELL = QW;
	localparam logic [DW-1:0] DIM_RESET = DW'(1) << FB;

	typedef enum logic [1:0] {
		REG_CENTER_X = 2'd0,
		REG_CENTER_Y = 2'd1,
		REG_CENTER_Z = 2'd2,
		REG_CUBE_DIM = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [DW-1:0] rem;
		logic [QW-1:0] num;
		logic [QW-1:0] quo;
	} lane_t;

	typedef struct packed {
		logic              in_cube;
		logic              zero;
		logic [2:0]        sgn;
		logic [2:0][CW-1:0] base;
	} side_t;

	typedef struct packed {
		logic [DW-1:0] den;
		lane_t [2:0]   lane;
		side_t         side;
	} div_t;

endpackage

// ===== rtl/cipu_div_cell.sv =====
module cipu_div_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  cipu_pkg::div_t     in_data,
	output logic               out_valid,
	output cipu_pkg::div_t     out_data
);

	logic           valid_q;
	cipu_pkg::div_t data_q;
	cipu_pkg::div_t nxt;
	logic [cipu_pkg::DW:0] t;
	logic ge;

	always_comb begin
		nxt = in_data;
		t = '0;
		ge = 1'b0;
		for (int a = 0; a < 3; a++) begin
			t = {in_data.lane[a].rem, in_data.lane[a].num[cipu_pkg::QW-1]};
			ge = t >= {1'b0, in_data.den};
			nxt.lane[a].rem = ge ? cipu_pkg::DW'(t - {1'b0, in_data.den})
				: cipu_pkg::DW'(t);
			nxt.lane[a].num = in_data.lane[a].num << 1;
			nxt.lane[a].quo = {in_data.lane[a].quo[cipu_pkg::QW-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

// ===== rtl/cipu_front.sv =====
module cipu_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             in_valid,
	input  logic [2:0][cipu_pkg::CW-1:0]     pos,
	input  logic [2:0][cipu_pkg::CW-1:0]     ctr,
	input  logic [cipu_pkg::DW-1:0]          dim,
	output logic                             out_valid,
	output cipu_pkg::div_t                   out_data
);

	logic                                  v_s1, v_s2, v_s3;
	logic signed [2:0][cipu_pkg::CW:0]     d_s1;
	logic [2:0][cipu_pkg::CW-1:0]          pos_s1, ctr_s1;

	logic [2:0][cipu_pkg::CW:0]            ab;
	logic [2:0]                            in_a;
	logic [2:0][cipu_pkg::AW-1:0]          mag;
	logic [cipu_pkg::AW-1:0]               mx;
	logic                                  ins;

	logic                                  inside_s2, zero_s2;
	logic [2:0]                            sgn_s2;
	logic [2:0][cipu_pkg::AW-1:0]          mag_s2;
	logic [cipu_pkg::AW-1:0]               m_s2;
	logic [2:0][cipu_pkg::CW-1:0]          base_s2;

	logic [2:0][cipu_pkg::NW-1:0]          prod;
	cipu_pkg::div_t                        data_s3;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			ab[a]   = d_s1[a][cipu_pkg::CW] ? (cipu_pkg::CW+1)'(0) - d_s1[a] : d_s1[a];
			in_a[a] = {ab[a], 1'b0} < {3'b000, dim};
			mag[a]  = ab[a][cipu_pkg::AW-1:0];
		end
		ins = &in_a;
		mx = mag[0];
		if (mag[1] > mx) mx = mag[1];
		if (mag[2] > mx) mx = mag[2];
		for (int a = 0; a < 3; a++) begin
			prod[a] = cipu_pkg::NW'(mag_s2[a]) * cipu_pkg::NW'(dim);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				d_s1[a] <= $signed({pos[a][cipu_pkg::CW-1], pos[a]})
					- $signed({ctr[a][cipu_pkg::CW-1], ctr[a]});
			end
			pos_s1 <= pos;
			ctr_s1 <= ctr;
			inside_s2 <= ins;
			zero_s2   <= ins && (mx == '0);
			for (int a = 0; a < 3; a++) begin
				sgn_s2[a] <= d_s1[a][cipu_pkg::CW];
			end
			mag_s2  <= mag;
			m_s2    <= mx;
			base_s2 <= ins ? ctr_s1 : pos_s1;
			for (int a = 0; a < 3; a++) begin
				data_s3.lane[a].rem <= prod[a][cipu_pkg::NW-1:cipu_pkg::QW];
				data_s3.lane[a].num <= prod[a][cipu_pkg::QW-1:0];
				data_s3.lane[a].quo <= '0;
			end
			data_s3.den          <= {m_s2, 1'b0};
			data_s3.side.in_cube <= inside_s2;
			data_s3.side.zero    <= zero_s2;
			data_s3.side.sgn     <= sgn_s2;
			data_s3.side.base    <= base_s2;
		end
	end

	assign out_valid = v_s3;
	assign out_data  = data_s3;

endmodule

// ===== rtl/cube_interior_pushout_unit.sv =====
// Cube interior push-out: each item is a vertex (x, y, z in signed Q16.16). A vertex strictly
// inside the configured cube (center, edge length) is moved along the ray from the center to the
// cube surface and flagged in m_tuser; any other vertex passes through unchanged. Results
// saturate to the coordinate range. One item per cycle while the output is not stalled. The
// pipeline has three setup stages (offset, magnitude and inside test, multiply), a chain of 30
// divider cells that each settle one quotient bit for all three axes, and the rounding and
// output register. The whole chain advances when the output register is empty or taken. Write
// the registers only while no item is in flight.
module cube_interior_pushout_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [3*cipu_pkg::CW-1:0]        s_tdata,  // pos_x, pos_y, pos_z
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [3*cipu_pkg::CW-1:0]        m_tdata,  // new_x, new_y, new_z
	output logic                             m_tuser,  // inside_res
	input  logic                             cfg_we,
	input  logic [1:0]                       cfg_index,
	input  logic [cipu_pkg::CW-1:0]          cfg_wdata
);

	logic [2:0][cipu_pkg::CW-1:0] ctr_q;
	logic [cipu_pkg::DW-1:0]      dim_q;
	logic [2:0][cipu_pkg::CW-1:0] pos;
	logic                         en;

	logic                         cv [0:cipu_pkg::NCELL];
	cipu_pkg::div_t               cd [0:cipu_pkg::NCELL];

	cipu_pkg::div_t               fin;
	logic [cipu_pkg::DW:0]        t;
	logic [cipu_pkg::QW:0]        qf;
	logic signed [cipu_pkg::CW+1:0] sum;
	logic [2:0][cipu_pkg::CW-1:0] res;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			pos[a] = s_tdata[a*cipu_pkg::CW +: cipu_pkg::CW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q <= '0;
			dim_q <= cipu_pkg::DIM_RESET;
		end else if (cfg_we) begin
			unique case (cipu_pkg::cfg_reg_t'(cfg_index))
				cipu_pkg::REG_CENTER_X: ctr_q[0] <= cfg_wdata;
				cipu_pkg::REG_CENTER_Y: ctr_q[1] <= cfg_wdata;
				cipu_pkg::REG_CENTER_Z: ctr_q[2] <= cfg_wdata;
				cipu_pkg::REG_CUBE_DIM: dim_q <= cfg_wdata[cipu_pkg::DW-1:0];
				default: ;
			endcase
		end
	end

	cipu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.pos       (pos),
		.ctr       (ctr_q),
		.dim       (dim_q),
		.out_valid (cv[0]),
		.out_data  (cd[0])
	);

	for (genvar i = 0; i < cipu_pkg::NCELL; i++) begin : g_cell
		cipu_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (cv[i]),
			.in_data   (cd[i]),
			.out_valid (cv[i+1]),
			.out_data  (cd[i+1])
		);
	end

	always_comb begin
		fin = cd[cipu_pkg::NCELL];
		t   = '0;
		qf  = '0;
		sum = '0;
		for (int a = 0; a < 3; a++) begin
			t  = {fin.lane[a].rem, 1'b0};
			qf = {1'b0, fin.lane[a].quo} + (cipu_pkg::QW+1)'(t >= {1'b0, fin.den});
			if (fin.side.zero) qf = '0;
			if (fin.side.sgn[a]) begin
				sum = $signed({{2{fin.side.base[a][cipu_pkg::CW-1]}}, fin.side.base[a]})
					- $signed({1'b0, (cipu_pkg::CW+1)'(qf)});
			end else begin
				sum = $signed({{2{fin.side.base[a][cipu_pkg::CW-1]}}, fin.side.base[a]})
					+ $signed({1'b0, (cipu_pkg::CW+1)'(qf)});
			end
			if (!fin.side.in_cube) begin
				res[a] = fin.side.base[a];
			end else if (sum[cipu_pkg::CW+1:cipu_pkg::CW-1] == 3'b000
				|| sum[cipu_pkg::CW+1:cipu_pkg::CW-1] == 3'b111) begin
				res[a] = sum[cipu_pkg::CW-1:0];
			end else if (sum[cipu_pkg::CW+1]) begin
				res[a] = {1'b1, {(cipu_pkg::CW-1){1'b0}}};
			end else begin
				res[a] = {1'b0, {(cipu_pkg::CW-1){1'b1}}};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= cv[cipu_pkg::NCELL];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= res;
			m_tuser <= fin.side.in_cube;
		end
	end

endmodule
